FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TAT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define TAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/tat_pkg.sv
// types and constants of the thermistor conversion block
package tat_pkg;

  localparam int SegCount = 9;

  // 330 ohm expressed in milliohm
  localparam logic [18:0] RES_SCALE = 19'd330000;
  // 5 degrees in hundredths, doubled for round half up
  localparam logic [9:0] TEMP_SCALE = 10'd1000;
  localparam logic [28:0] RES_SAT = 29'h1FFF_FFFF;

  // segment bounds in milliohm, falling
  localparam logic [20:0] BOUND [10] = '{
    21'd1665000, 21'd1248000, 21'd942300, 21'd717100, 21'd549800,
    21'd424500, 21'd330000, 21'd258200, 21'd203400, 21'd161100
  };

  // upper bound of each segment minus its lower bound
  localparam logic [18:0] SEG_SPAN [SegCount] = '{
    19'd417000, 19'd305700, 19'd225200, 19'd167300, 19'd125300,
    19'd94500, 19'd71800, 19'd54800, 19'd42300
  };

  // temperature at the upper bound of each segment, 0.01 C
  localparam logic signed [12:0] SEG_BASE [SegCount] = '{
    -13'sd500, 13'sd0, 13'sd500, 13'sd1000, 13'sd1500,
    13'sd2000, 13'sd2500, 13'sd3000, 13'sd3500
  };

  typedef struct packed {
    logic tick_take;
    logic mul_load;
    logic r_sat;
    logic div_start;
    logic div_temp;
    logic r_load;
    logic seg_load;
    logic tmul_load;
    logic t_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic fire;
    logic sample_zero;
    logic div_done;
    logic in_range;
    logic out_free;
  } dp_status_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL   = 10'b00_0000_0010,
    S_RGO   = 10'b00_0000_0100,
    S_RWAIT = 10'b00_0000_1000,
    S_SEG   = 10'b00_0001_0000,
    S_TMUL  = 10'b00_0010_0000,
    S_TGO   = 10'b00_0100_0000,
    S_TWAIT = 10'b00_1000_0000,
    S_OUT   = 10'b01_0000_0000,
    S_SPARE = 10'b10_0000_0000
  } state_t;

endpackage

FILE: rtl/tat_if.sv
// channel interfaces: adc tick, configuration write, conversion result
interface tat_tick_if;
  logic       valid;
  logic       ready;
  logic [9:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface tat_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_interval;
  modport source (output valid, output sample_interval, input ready);
  modport sink (input valid, input sample_interval, output ready);
endinterface

interface tat_result_if;
  logic               valid;
  logic               ready;
  logic               in_range;
  logic signed [12:0] temperature_centi;
  logic [28:0]        resistance_milliohm;
  logic [9:0]         sample_echo;
  modport source (output valid, output in_range, output temperature_centi,
                  output resistance_milliohm, output sample_echo, input ready);
  modport sink (input valid, input in_range, input temperature_centi,
                input resistance_milliohm, input sample_echo, output ready);
endinterface

FILE: rtl/tat_div.sv
// restoring divider, one quotient bit per cycle, long or short run
module tat_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        short_run,
  input  logic [29:0] num,
  input  logic [19:0] den,
  output logic        busy,
  output logic [29:0] quo
);

  localparam int NumW = 30;
  localparam int DenW = 20;
  localparam int AccW = NumW + DenW + 1;
  localparam int LongSteps = NumW;
  localparam int ShortSteps = 10;
  localparam int Pad = NumW - ShortSteps;

  logic [AccW-1:0] acc;
  logic [AccW-1:0] acc_next;
  logic [DenW-1:0] den_q;
  logic [4:0]      cnt;
  logic [DenW:0]   rem;

  always_comb begin
    acc_next = {acc[AccW-2:0], 1'b0};
    rem = acc_next[AccW-1:NumW];
    if (rem >= {1'b0, den_q}) begin
      acc_next[AccW-1:NumW] = rem - {1'b0, den_q};
      acc_next[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 5'd1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_q <= den;
      if (short_run) begin
        // quotient known to fit in the short run's bits
        acc <= AccW'({num, {Pad{1'b0}}});
        cnt <= 5'(ShortSteps);
      end else begin
        acc <= AccW'(num);
        cnt <= 5'(LongSteps);
      end
    end else if (busy) begin
      acc <= acc_next;
      cnt <= cnt - 5'd1;
    end
  end

  assign quo = acc[NumW-1:0];

endmodule

FILE: rtl/tat_datapath.sv
// datapath: tick counter, resistance and segment arithmetic, result register
module tat_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tat_pkg::dp_cmd_t    cmd,
  output tat_pkg::dp_status_t status,
  input  logic [9:0]          adc_sample,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_interval,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_in_range,
  output logic signed [12:0]  out_temp,
  output logic [28:0]         out_res,
  output logic [9:0]          out_sample
);

  logic [15:0]        interval;
  logic [15:0]        tick_count;
  logic [16:0]        count_inc;
  logic [9:0]         sample;
  logic [28:0]        prod;
  logic [28:0]        res;
  logic               in_range;
  logic [3:0]         seg_k;
  logic [29:0]        tnum;
  logic signed [12:0] temp;
  logic [3:0]         seg_cnt;
  logic               seg_hit;
  logic [20:0]        seg_diff;
  logic [28:0]        tprod;
  logic [29:0]        div_num;
  logic [19:0]        div_den;
  logic               div_busy;
  logic [29:0]        div_quo;

  assign count_inc = {1'b0, tick_count} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= 16'd5000;
      tick_count <= '0;
    end else begin
      if (cfg_we) begin
        interval <= cfg_interval;
      end
      if (cmd.tick_take) begin
        tick_count <= status.fire ? 16'd0 : count_inc[15:0];
      end
    end
  end

  // segment search over the falling bounds
  always_comb begin
    seg_cnt = '0;
    for (int j = 1; j < tat_pkg::SegCount; j++) begin
      seg_cnt = seg_cnt + 4'({8'b0, tat_pkg::BOUND[j]} > res);
    end
    seg_hit = (res >= {8'b0, tat_pkg::BOUND[tat_pkg::SegCount]}) &&
              (res < {8'b0, tat_pkg::BOUND[0]});
  end

  assign seg_diff = tat_pkg::BOUND[seg_k] - res[20:0];
  assign tprod = seg_diff[18:0] * tat_pkg::TEMP_SCALE;

  assign div_num = cmd.div_temp ? tnum : ({prod, 1'b0} + {20'b0, sample});
  assign div_den = cmd.div_temp ? {tat_pkg::SEG_SPAN[seg_k], 1'b0}
                                : {9'b0, sample, 1'b0};

  tat_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .short_run (cmd.div_temp),
    .num       (div_num),
    .den       (div_den),
    .busy      (div_busy),
    .quo       (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.tick_take) begin
      sample <= adc_sample;
    end
    if (cmd.mul_load) begin
      prod <= tat_pkg::RES_SCALE * (10'd1023 - sample);
    end
    if (cmd.r_sat) begin
      res <= tat_pkg::RES_SAT;
      in_range <= 1'b0;
      temp <= '0;
    end else if (cmd.r_load) begin
      res <= div_quo[28:0];
    end
    if (cmd.seg_load) begin
      in_range <= seg_hit;
      seg_k <= seg_cnt;
      temp <= '0;
    end
    if (cmd.tmul_load) begin
      tnum <= {1'b0, tprod} + {11'b0, tat_pkg::SEG_SPAN[seg_k]};
    end
    if (cmd.t_load) begin
      temp <= tat_pkg::SEG_BASE[seg_k] + $signed({3'b0, div_quo[9:0]});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_in_range <= in_range;
      out_temp <= temp;
      out_res <= res;
      out_sample <= sample;
    end
  end

  assign status.fire = count_inc >= {1'b0, interval};
  assign status.sample_zero = sample == 10'd0;
  assign status.div_done = !div_busy;
  assign status.in_range = in_range;
  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/tat_ctrl.sv
// controller: sequences one conversion through the datapath
module tat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_ready,
  input  tat_pkg::dp_status_t status,
  output tat_pkg::dp_cmd_t    cmd
);

  tat_pkg::state_t state;
  tat_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    tick_ready = 1'b0;
    case (state)
      tat_pkg::S_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.tick_take = 1'b1;
          if (status.fire) begin
            state_next = tat_pkg::S_MUL;
          end
        end
      end
      tat_pkg::S_MUL: begin
        if (status.sample_zero) begin
          cmd.r_sat = 1'b1;
          state_next = tat_pkg::S_OUT;
        end else begin
          cmd.mul_load = 1'b1;
          state_next = tat_pkg::S_RGO;
        end
      end
      tat_pkg::S_RGO: begin
        cmd.div_start = 1'b1;
        state_next = tat_pkg::S_RWAIT;
      end
      tat_pkg::S_RWAIT: begin
        if (status.div_done) begin
          cmd.r_load = 1'b1;
          state_next = tat_pkg::S_SEG;
        end
      end
      tat_pkg::S_SEG: begin
        cmd.seg_load = 1'b1;
        state_next = tat_pkg::S_TMUL;
      end
      tat_pkg::S_TMUL: begin
        if (status.in_range) begin
          cmd.tmul_load = 1'b1;
          state_next = tat_pkg::S_TGO;
        end else begin
          state_next = tat_pkg::S_OUT;
        end
      end
      tat_pkg::S_TGO: begin
        cmd.div_start = 1'b1;
        cmd.div_temp = 1'b1;
        state_next = tat_pkg::S_TWAIT;
      end
      tat_pkg::S_TWAIT: begin
        cmd.div_temp = 1'b1;
        if (status.div_done) begin
          cmd.t_load = 1'b1;
          state_next = tat_pkg::S_OUT;
        end
      end
      tat_pkg::S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = tat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tat_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/thermistor_adc_to_temperature.sv
// top level: tick-paced thermistor resistance and temperature conversion
// a tick that does not reach the interval only advances the count and gives no beat
// a converting tick leads to its result beat: a resistance division
// and an interpolation division share one divider
// the next tick is accepted once the result sits in the output register
// rst (synchronous) clears the tick count, sets the interval to 5000, drops valid
`include "assert_macros.svh"

module thermistor_adc_to_temperature (
  input logic          clk,
  input logic          rst,
  tat_tick_if.sink     tick,
  tat_cfg_if.sink      cfg,
  tat_result_if.source result
);

  tat_pkg::dp_cmd_t    cmd;
  tat_pkg::dp_status_t status;
  logic                in_ready;

  // interval register accepts a write beat in any cycle
  assign cfg.ready = 1'b1;
  assign tick.ready = in_ready;

  // sequencer: idle, multiply, divide, segment, interpolate, hand off
  tat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // arithmetic, tick counter and result register
  tat_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .adc_sample   (tick.adc_sample),
    .cfg_we       (cfg.valid),
    .cfg_interval (cfg.sample_interval),
    .out_ready    (result.ready),
    .out_valid    (result.valid),
    .out_in_range (result.in_range),
    .out_temp     (result.temperature_centi),
    .out_res      (result.resistance_milliohm),
    .out_sample   (result.sample_echo)
  );

  // the divider is never busy while ticks are taken
  `TAT_ASSERT_NOW(a_idle_div_free, clk, rst, in_ready, status.div_done)
  // the result register is only loaded when it can take the beat
  `TAT_ASSERT_NOW(a_load_free, clk, rst, cmd.out_load, status.out_free)
  // a converting tick closes the input until the conversion is done
  `TAT_ASSERT_NEXT(a_fire_busy, clk, rst, tick.valid && in_ready && status.fire, !in_ready)
  // an out-of-range result carries zero temperature
  `TAT_ASSERT_NOW(a_range_zero, clk, rst, result.valid && !result.in_range,
                  result.temperature_centi == 13'sd0)

endmodule
